// File: rtl/core/dhc_pkg.sv
// dhc_pkg: shared types and constants of the depth-to-hue colormap unit.
// No dependencies; used by every module under rtl/core.

package dhc_pkg;

   // Widths of the fixed fields
   localparam int DEPTH_W  = 16;
   localparam int CHAN_W   = 8;
   localparam int SECTOR_W = 3;
   localparam int BITS_W   = 8;
   localparam int CSR_IDX_W = 1;

   // Cell counts of the two division passes
   localparam int SECTOR_CELLS = 3;
   localparam int RAMP_CELLS   = 8;

   // Input beat to result strobe, in cycles
   localparam int LATENCY = 2 + SECTOR_CELLS + 1 + RAMP_CELLS + 1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_LOW  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_HIGH = 1'b1;

   // Register reset values
   localparam logic [DEPTH_W-1:0] RANGE_LOW_RESET  = 16'd500;
   localparam logic [DEPTH_W-1:0] RANGE_HIGH_RESET = 16'd5800;

   // Hue sectors, red end first
   localparam logic [SECTOR_W-1:0] SECTOR_RED    = 3'd0;
   localparam logic [SECTOR_W-1:0] SECTOR_YELLOW = 3'd1;
   localparam logic [SECTOR_W-1:0] SECTOR_GREEN  = 3'd2;
   localparam logic [SECTOR_W-1:0] SECTOR_CYAN   = 3'd3;
   localparam logic [SECTOR_W-1:0] SECTOR_BLUE   = 3'd4;

   localparam logic [CHAN_W-1:0] CHAN_FULL = 8'd255;

   // One pixel moving down the cell chain
   typedef struct packed {
      logic                valid;
      logic                black;   // no reading
      logic                blue;    // empty or inverted range
      logic                frame;
      logic [SECTOR_W-1:0] sector;
      logic [DEPTH_W-1:0]  den;
      logic [DEPTH_W-1:0]  rem;     // partial remainder
      logic [BITS_W-1:0]   bits;    // dividend bits out, quotient bits in
   } beat_type;

endpackage

// File: rtl/core/depth_to_hue_colormap_unit.sv
// depth_to_hue_colormap_unit: top level, depth pixel in, RGB pixel out.
// Depends on dhc_pkg, dhc_prep, dhc_div_cell, dhc_ramp.
//
//   channel  ports                              handshake
//   -------  ---------------------------------  ---------------------------
//   request  req_depth_mm, req_frame_end        start && !busy
//   result   rsp_red/green/blue, rsp_frame_last rsp_valid, one-cycle strobe
//   config   csr_index, csr_wdata               csr_valid && csr_ready
//
// One pixel is taken every cycle while busy is low; each result strobes
// once its beat has passed the prep stages, 3 sector cells, the ramp
// stage, 8 ramp cells and output stage. Reset is synchronous; busy is
// high for the cycle after reset and low otherwise. The receiver cannot
// stall, so the chain always advances and csr_ready is always high.

module depth_to_hue_colormap_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [dhc_pkg::DEPTH_W-1:0]   req_depth_mm,
   input  logic                          req_frame_end,
   output logic                          rsp_valid,
   output logic [dhc_pkg::CHAN_W-1:0]    rsp_red,
   output logic [dhc_pkg::CHAN_W-1:0]    rsp_green,
   output logic [dhc_pkg::CHAN_W-1:0]    rsp_blue,
   output logic                          rsp_frame_last,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [dhc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [dhc_pkg::DEPTH_W-1:0]   csr_wdata
);

   logic                          busy_ff;
   logic                          accept;
   logic [dhc_pkg::DEPTH_W-1:0]   range_low_ff;
   logic [dhc_pkg::DEPTH_W-1:0]   range_high_ff;

   dhc_pkg::beat_type             sector_chain [0:dhc_pkg::SECTOR_CELLS];
   dhc_pkg::beat_type             ramp_chain   [0:dhc_pkg::RAMP_CELLS];
   dhc_pkg::beat_type             last_beat;

   logic [dhc_pkg::CHAN_W-1:0]    up;
   logic [dhc_pkg::CHAN_W-1:0]    down;
   logic [dhc_pkg::CHAN_W-1:0]    red_in;
   logic [dhc_pkg::CHAN_W-1:0]    green_in;
   logic [dhc_pkg::CHAN_W-1:0]    blue_in;
   logic                          valid_ff;
   logic [dhc_pkg::CHAN_W-1:0]    red_ff;
   logic [dhc_pkg::CHAN_W-1:0]    green_ff;
   logic [dhc_pkg::CHAN_W-1:0]    blue_ff;
   logic                          frame_ff;

   // Hold busy for one cycle out of reset
   always_ff @(posedge clock) begin
      busy_ff <= reset;
   end

   assign busy      = busy_ff;
   assign accept    = start && !busy_ff;
   assign csr_ready = 1'b1;

   // Take register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         range_low_ff  <= dhc_pkg::RANGE_LOW_RESET;
         range_high_ff <= dhc_pkg::RANGE_HIGH_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            dhc_pkg::CSR_RANGE_LOW:  range_low_ff  <= csr_wdata;
            dhc_pkg::CSR_RANGE_HIGH: range_high_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Clamp and seed the sector pass
   dhc_prep u_prep (
      .clock        (clock),
      .reset        (reset),
      .valid_i      (accept),
      .depth_i      (req_depth_mm),
      .frame_i      (req_frame_end),
      .range_low_i  (range_low_ff),
      .range_high_i (range_high_ff),
      .beat_o       (sector_chain[0])
   );

   // Sector pass: 4*(high-d) / (high-low)
   for (genvar i = 0; i < dhc_pkg::SECTOR_CELLS; i++) begin : g_sector
      dhc_div_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .beat_i (sector_chain[i]),
         .beat_o (sector_chain[i+1])
      );
   end

   dhc_ramp u_ramp (
      .clock  (clock),
      .reset  (reset),
      .beat_i (sector_chain[dhc_pkg::SECTOR_CELLS]),
      .beat_o (ramp_chain[0])
   );

   // Ramp pass: 255*rem / (high-low)
   for (genvar i = 0; i < dhc_pkg::RAMP_CELLS; i++) begin : g_ramp
      dhc_div_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .beat_i (ramp_chain[i]),
         .beat_o (ramp_chain[i+1])
      );
   end

   assign last_beat = ramp_chain[dhc_pkg::RAMP_CELLS];

   // Rising ramp is the quotient; falling ramp is 255 minus its ceiling
   always_comb begin
      up   = last_beat.bits;
      down = dhc_pkg::CHAN_FULL - up
           - {{(dhc_pkg::CHAN_W-1){1'b0}}, last_beat.rem != '0};
   end

   // Pick the color: black for no reading, blue for an empty or inverted range, else by sector
   always_comb begin
      red_in   = '0;
      green_in = '0;
      blue_in  = '0;
      if (last_beat.black) begin
         blue_in = '0;
      end else if (last_beat.blue) begin
         blue_in = dhc_pkg::CHAN_FULL;
      end else begin
         case (last_beat.sector)
            dhc_pkg::SECTOR_RED: begin
               red_in   = dhc_pkg::CHAN_FULL;
               green_in = up;
            end
            dhc_pkg::SECTOR_YELLOW: begin
               red_in   = down;
               green_in = dhc_pkg::CHAN_FULL;
            end
            dhc_pkg::SECTOR_GREEN: begin
               green_in = dhc_pkg::CHAN_FULL;
               blue_in  = up;
            end
            dhc_pkg::SECTOR_CYAN: begin
               green_in = down;
               blue_in  = dhc_pkg::CHAN_FULL;
            end
            default: begin
               blue_in = dhc_pkg::CHAN_FULL;
            end
         endcase
      end
   end

   // Register the result beat
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= last_beat.valid;
      end
   end

   always_ff @(posedge clock) begin
      red_ff   <= red_in;
      green_ff <= green_in;
      blue_ff  <= blue_in;
      frame_ff <= last_beat.frame;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_red        = red_ff;
   assign rsp_green      = green_ff;
   assign rsp_blue       = blue_ff;
   assign rsp_frame_last = frame_ff;

   // A result strobes only for a matching request beat taken by the unit
   a_latency : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, dhc_pkg::LATENCY))
      else $error("result without a matching request beat");

   // No reading gives black
   a_black : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(accept && req_depth_mm == '0, dhc_pkg::LATENCY)
      |-> (rsp_red == '0 && rsp_green == '0 && rsp_blue == '0))
      else $error("zero depth did not give black");

   // Division leaves a sector of at most four and a remainder below range
   a_divide : assert property (@(posedge clock) disable iff (reset)
      last_beat.valid && !last_beat.black && !last_beat.blue
      |-> (last_beat.sector <= dhc_pkg::SECTOR_BLUE && last_beat.rem < last_beat.den))
      else $error("division chain out of bounds");

   // Full saturation: some channel at full scale unless black
   a_saturation : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_red == dhc_pkg::CHAN_FULL || rsp_green == dhc_pkg::CHAN_FULL ||
                     rsp_blue == dhc_pkg::CHAN_FULL ||
                     (rsp_red | rsp_green | rsp_blue) == '0))
      else $error("color not at full saturation");

endmodule

// File: rtl/core/dhc_div_cell.sv
// dhc_div_cell: one restoring-division step, registered.
// Depends on dhc_pkg (beat_type).

module dhc_div_cell (
   input  logic              clock,
   input  logic              reset,
   input  dhc_pkg::beat_type beat_i,
   output dhc_pkg::beat_type beat_o
);

   dhc_pkg::beat_type beat_ff;
   dhc_pkg::beat_type beat_in;

   logic [dhc_pkg::DEPTH_W:0] trial;
   logic                      fits;

   // Shift in the next dividend bit, subtract the divisor when it fits
   always_comb begin
      trial   = {beat_i.rem, beat_i.bits[dhc_pkg::BITS_W-1]};
      fits    = trial >= {1'b0, beat_i.den};
      beat_in = beat_i;
      beat_in.rem  = fits ? dhc_pkg::DEPTH_W'(trial - {1'b0, beat_i.den})
                          : trial[dhc_pkg::DEPTH_W-1:0];
      beat_in.bits = {beat_i.bits[dhc_pkg::BITS_W-2:0], fits};
   end

   // Hand the beat to the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff.valid <= 1'b0;
      end else begin
         beat_ff <= beat_in;
      end
   end

   assign beat_o = beat_ff;

endmodule

// File: rtl/core/dhc_prep.sv
// dhc_prep: clamps the depth and loads the first division cell (two stages).
// Depends on dhc_pkg (beat_type, widths).

module dhc_prep (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        valid_i,
   input  logic [dhc_pkg::DEPTH_W-1:0] depth_i,
   input  logic                        frame_i,
   input  logic [dhc_pkg::DEPTH_W-1:0] range_low_i,
   input  logic [dhc_pkg::DEPTH_W-1:0] range_high_i,
   output dhc_pkg::beat_type           beat_o
);

   dhc_pkg::beat_type           clamp_ff;
   dhc_pkg::beat_type           clamp_in;
   dhc_pkg::beat_type           load_ff;
   dhc_pkg::beat_type           load_in;
   logic [dhc_pkg::DEPTH_W-1:0] diff;

   // Stage one: flags, range width and clamped depth (kept in rem)
   always_comb begin
      clamp_in        = '0;
      clamp_in.valid  = valid_i;
      clamp_in.black  = depth_i == '0;
      clamp_in.blue   = range_low_i >= range_high_i;
      clamp_in.frame  = frame_i;
      clamp_in.den    = range_high_i - range_low_i;
      if (depth_i > range_high_i) begin
         clamp_in.rem = range_high_i;
      end else if (depth_i < range_low_i) begin
         clamp_in.rem = range_low_i;
      end else begin
         clamp_in.rem = depth_i;
      end
   end

   // Stage two: dividend 4*(high-d); top bits seed the remainder, which
   // stays below the divisor since the sector is at most four
   always_comb begin
      diff         = range_high_i - clamp_ff.rem;
      load_in      = clamp_ff;
      load_in.rem  = {1'b0, diff[dhc_pkg::DEPTH_W-1:1]};
      load_in.bits = {diff[0], {(dhc_pkg::BITS_W-1){1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clamp_ff.valid <= 1'b0;
         load_ff.valid  <= 1'b0;
      end else begin
         clamp_ff <= clamp_in;
         load_ff  <= load_in;
      end
   end

   assign beat_o = load_ff;

endmodule

// File: rtl/core/dhc_ramp.sv
// dhc_ramp: takes the sector and remainder, forms 255*rem for the ramp pass.
// Depends on dhc_pkg (beat_type, widths).

module dhc_ramp (
   input  logic              clock,
   input  logic              reset,
   input  dhc_pkg::beat_type beat_i,
   output dhc_pkg::beat_type beat_o
);

   localparam int PROD_W = dhc_pkg::DEPTH_W + dhc_pkg::BITS_W;

   dhc_pkg::beat_type  beat_ff;
   dhc_pkg::beat_type  beat_in;
   logic [PROD_W-1:0]  prod;

   // 255*rem as (rem << 8) - rem; quotient stays under 256
   always_comb begin
      prod = {beat_i.rem, {dhc_pkg::BITS_W{1'b0}}}
           - {{dhc_pkg::BITS_W{1'b0}}, beat_i.rem};
      beat_in        = beat_i;
      beat_in.sector = beat_i.bits[dhc_pkg::SECTOR_W-1:0];
      beat_in.rem    = prod[PROD_W-1:dhc_pkg::BITS_W];
      beat_in.bits   = prod[dhc_pkg::BITS_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff.valid <= 1'b0;
      end else begin
         beat_ff <= beat_in;
      end
   end

   assign beat_o = beat_ff;

endmodule

// File: tb/depth_hue_checker.sv
// depth_hue_checker: watches the pixel, result and register channels of the
// depth-to-hue colormap unit, predicts every colour and compares it.
// Depends on dhc_pkg for widths, register indexes and sector codes.
`timescale 1ns / 1ps

module depth_hue_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic [dhc_pkg::DEPTH_W-1:0]   req_depth_mm,
   input  logic                          req_frame_end,
   input  logic                          rsp_valid,
   input  logic [dhc_pkg::CHAN_W-1:0]    rsp_red,
   input  logic [dhc_pkg::CHAN_W-1:0]    rsp_green,
   input  logic [dhc_pkg::CHAN_W-1:0]    rsp_blue,
   input  logic                          rsp_frame_last,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [dhc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [dhc_pkg::DEPTH_W-1:0]   csr_wdata,
   output int                            pending_count,
   output int                            mismatch_count
);

   typedef struct packed {
      logic [dhc_pkg::CHAN_W-1:0] red;
      logic [dhc_pkg::CHAN_W-1:0] green;
      logic [dhc_pkg::CHAN_W-1:0] blue;
      logic                       frame_last;
   } pixel_color_type;

   // Shadow copy of the range registers
   logic [dhc_pkg::DEPTH_W-1:0] range_low_ff;
   logic [dhc_pkg::DEPTH_W-1:0] range_high_ff;

   // Colors owed by the unit, oldest first
   pixel_color_type color_q[$];

   // Map one depth onto the hue wheel: blue at the near bound, red at the far one
   function automatic pixel_color_type map_depth_to_color(
      input logic [dhc_pkg::DEPTH_W-1:0] depth,
      input logic                        frame,
      input logic [dhc_pkg::DEPTH_W-1:0] lo,
      input logic [dhc_pkg::DEPTH_W-1:0] hi
   );
      pixel_color_type c;
      logic [31:0] d, den, num, rem, up, down;
      logic [dhc_pkg::SECTOR_W-1:0] sector;
      c.red = '0;
      c.green = '0;
      c.blue = '0;
      c.frame_last = frame;
      if (depth == '0) begin
         // no reading: black
      end else if (lo >= hi) begin
         c.blue = dhc_pkg::CHAN_FULL;
      end else begin
         // saturate to the range, then split into sector and ramp
         d = 32'(depth);
         if (d > 32'(hi)) d = 32'(hi);
         if (d < 32'(lo)) d = 32'(lo);
         den = 32'(hi) - 32'(lo);
         num = 4 * (32'(hi) - d);
         sector = dhc_pkg::SECTOR_W'(num / den);
         rem = num % den;
         up = (255 * rem) / den;
         down = (255 * (den - rem)) / den;
         case (sector)
            dhc_pkg::SECTOR_RED: begin
               c.red = dhc_pkg::CHAN_FULL;
               c.green = up[dhc_pkg::CHAN_W-1:0];
            end
            dhc_pkg::SECTOR_YELLOW: begin
               c.red = down[dhc_pkg::CHAN_W-1:0];
               c.green = dhc_pkg::CHAN_FULL;
            end
            dhc_pkg::SECTOR_GREEN: begin
               c.green = dhc_pkg::CHAN_FULL;
               c.blue = up[dhc_pkg::CHAN_W-1:0];
            end
            dhc_pkg::SECTOR_CYAN: begin
               c.green = down[dhc_pkg::CHAN_W-1:0];
               c.blue = dhc_pkg::CHAN_FULL;
            end
            default: begin
               c.blue = dhc_pkg::CHAN_FULL;
            end
         endcase
      end
      return c;
   endfunction

   // Check result beats, queue predictions for pixel beats, track register writes
   always @(posedge clock) begin : watch
      int errs;
      int pushes;
      int pops;
      pixel_color_type want;
      errs = 0;
      pushes = 0;
      pops = 0;
      if (reset) begin
         range_low_ff <= dhc_pkg::RANGE_LOW_RESET;
         range_high_ff <= dhc_pkg::RANGE_HIGH_RESET;
         color_q.delete();
         pending_count <= 0;
      end else begin
         if (rsp_valid) begin
            if (color_q.size() == 0) begin
               $error("result beat with no color expected: r=%0d g=%0d b=%0d last=%0b",
                      rsp_red, rsp_green, rsp_blue, rsp_frame_last);
               errs++;
            end else begin
               want = color_q.pop_front();
               pops = 1;
               if (rsp_red !== want.red) begin
                  $error("red: expected %0d, got %0d", want.red, rsp_red);
                  errs++;
               end
               if (rsp_green !== want.green) begin
                  $error("green: expected %0d, got %0d", want.green, rsp_green);
                  errs++;
               end
               if (rsp_blue !== want.blue) begin
                  $error("blue: expected %0d, got %0d", want.blue, rsp_blue);
                  errs++;
               end
               if (rsp_frame_last !== want.frame_last) begin
                  $error("frame_last: expected %0b, got %0b", want.frame_last,
                         rsp_frame_last);
                  errs++;
               end
            end
         end
         if (start && !busy) begin
            color_q.push_back(map_depth_to_color(req_depth_mm, req_frame_end,
                                                 range_low_ff, range_high_ff));
            pushes = 1;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               dhc_pkg::CSR_RANGE_LOW:  range_low_ff <= csr_wdata;
               dhc_pkg::CSR_RANGE_HIGH: range_high_ff <= csr_wdata;
               default: ;
            endcase
         end
         pending_count <= pending_count + pushes - pops;
      end
      mismatch_count <= mismatch_count + errs;
   end

endmodule

// File: tb/tb_depth_to_hue_colormap_unit.sv
// tb_depth_to_hue_colormap_unit: drives pixels and range writes into the
// colormap unit and gives the verdict; depends on dhc_pkg, the unit and
// depth_hue_checker, which predicts and compares every color.
`timescale 1ns / 1ps

module tb_depth_to_hue_colormap_unit;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_PIXELS = 103;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   logic [dhc_pkg::DEPTH_W-1:0]   req_depth_mm = '0;
   logic                          req_frame_end = 1'b0;
   logic                          rsp_valid;
   logic [dhc_pkg::CHAN_W-1:0]    rsp_red;
   logic [dhc_pkg::CHAN_W-1:0]    rsp_green;
   logic [dhc_pkg::CHAN_W-1:0]    rsp_blue;
   logic                          rsp_frame_last;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [dhc_pkg::CSR_IDX_W-1:0] csr_index = dhc_pkg::CSR_RANGE_LOW;
   logic [dhc_pkg::DEPTH_W-1:0]   csr_wdata = '0;

   int pending_count;
   int mismatch_count;
   int idle_cycles = 0;

   // Range currently programmed, used to aim the random depths
   logic [dhc_pkg::DEPTH_W-1:0] cur_low = dhc_pkg::RANGE_LOW_RESET;
   logic [dhc_pkg::DEPTH_W-1:0] cur_high = dhc_pkg::RANGE_HIGH_RESET;

   always #5 clock = ~clock;

   depth_to_hue_colormap_unit dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_depth_mm   (req_depth_mm),
      .req_frame_end  (req_frame_end),
      .rsp_valid      (rsp_valid),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .rsp_frame_last (rsp_frame_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   depth_hue_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_depth_mm   (req_depth_mm),
      .req_frame_end  (req_frame_end),
      .rsp_valid      (rsp_valid),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .rsp_frame_last (rsp_frame_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .pending_count  (pending_count),
      .mismatch_count (mismatch_count)
   );

   // Drop the run if no beat of any kind moves for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("depth_to_hue_colormap_unit test failed");
         $finish;
      end
   end

   // Offer one pixel after an optional gap and hold it until it is taken
   task automatic send_pixel(input logic [dhc_pkg::DEPTH_W-1:0] depth, input logic frame,
                             input int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_depth_mm <= depth;
      req_frame_end <= frame;
      do @(posedge clock); while (busy);
   endtask

   // Drain the unit, then program both range bounds back to back
   task automatic set_range(input logic [dhc_pkg::DEPTH_W-1:0] lo,
                            input logic [dhc_pkg::DEPTH_W-1:0] hi);
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= dhc_pkg::CSR_RANGE_LOW;
      csr_wdata <= lo;
      do @(posedge clock); while (!csr_ready);
      csr_index <= dhc_pkg::CSR_RANGE_HIGH;
      csr_wdata <= hi;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cur_low = lo;
      cur_high = hi;
   endtask

   // Mostly no gap, some short ones, a few long ones
   function automatic int pick_gap(input bit burst);
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (burst || sel < 50) return 0;
      if (sel < 90) return $urandom_range(1, 3);
      if (sel < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Aim depths inside the range and at its bounds, with misses and noise
   function automatic logic [dhc_pkg::DEPTH_W-1:0] pick_depth(
      input logic [dhc_pkg::DEPTH_W-1:0] lo,
      input logic [dhc_pkg::DEPTH_W-1:0] hi
   );
      int unsigned sel;
      int v;
      sel = $urandom_range(0, 99);
      if (sel < 10) v = 0;
      else if (sel < 55 && lo < hi) v = $urandom_range(int'(hi), int'(lo));
      else if (sel < 70) v = ($urandom_range(0, 1) ? int'(lo) : int'(hi))
                             + int'($urandom_range(0, 6)) - 3;
      else if (sel < 75) v = 65535 - int'($urandom_range(0, 3));
      else if (sel < 80) v = $urandom_range(1, 8);
      else v = $urandom_range(0, 65535);
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      return v[dhc_pkg::DEPTH_W-1:0];
   endfunction

   initial begin : stimulus
      int kind;
      int span;
      bit burst;
      logic [dhc_pkg::DEPTH_W-1:0] lo;
      logic [dhc_pkg::DEPTH_W-1:0] hi;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Reset range: bounds, sector boundaries, out of range, bit patterns
      send_pixel(16'd0, 1'b1, 0);
      send_pixel(16'd1, 1'b0, 0);
      send_pixel(16'd499, 1'b0, pick_gap(1'b0));
      send_pixel(16'd500, 1'b1, 0);
      send_pixel(16'd501, 1'b0, 0);
      send_pixel(16'd1824, 1'b0, pick_gap(1'b0));
      send_pixel(16'd1825, 1'b0, 0);
      send_pixel(16'd3150, 1'b0, 0);
      send_pixel(16'd4475, 1'b0, 0);
      send_pixel(16'd4476, 1'b0, pick_gap(1'b0));
      send_pixel(16'd5799, 1'b0, 0);
      send_pixel(16'd5800, 1'b0, 0);
      send_pixel(16'd5801, 1'b1, 0);
      send_pixel(16'hFFFF, 1'b0, 0);
      send_pixel(16'h5555, 1'b0, 0);
      send_pixel(16'hAAAA, 1'b1, 0);

      // Empty range, inverted range, full range
      set_range(16'd100, 16'd100);
      send_pixel(16'd0, 1'b0, 0);
      send_pixel(16'd100, 1'b1, 0);
      set_range(16'd6000, 16'd500);
      send_pixel(16'd3000, 1'b0, 0);
      set_range(16'd0, 16'hFFFF);
      send_pixel(16'hFFFF, 1'b1, 0);
      send_pixel(16'd1, 1'b0, 0);
      send_pixel(16'h8000, 1'b0, pick_gap(1'b0));

      // Random phases, each under its own range setting
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         kind = (phase < 7) ? phase : $urandom_range(0, 6);
         case (kind)
            0: begin
               lo = 16'd0;
               hi = 16'hFFFF;
            end
            1: begin
               lo = dhc_pkg::RANGE_LOW_RESET;
               hi = dhc_pkg::RANGE_HIGH_RESET;
            end
            2: begin
               lo = dhc_pkg::DEPTH_W'($urandom_range(0, 65527));
               hi = lo + dhc_pkg::DEPTH_W'($urandom_range(1, 8));
            end
            3: begin
               lo = dhc_pkg::DEPTH_W'($urandom_range(0, 65535));
               hi = dhc_pkg::DEPTH_W'($urandom_range(0, int'(lo)));
            end
            4: begin
               lo = 16'hFFFE;
               hi = 16'hFFFF;
            end
            5: begin
               lo = 16'd0;
               hi = dhc_pkg::DEPTH_W'($urandom_range(1, 4));
            end
            default: begin
               lo = dhc_pkg::DEPTH_W'($urandom_range(0, 65534));
               span = $urandom_range(1, 65535 - int'(lo));
               hi = lo + dhc_pkg::DEPTH_W'(span);
            end
         endcase
         set_range(lo, hi);
         burst = (phase == 2) || ($urandom_range(0, 3) == 0);
         for (int n = 0; n < PHASE_PIXELS; n++) begin
            send_pixel(pick_depth(cur_low, cur_high), ($urandom_range(0, 7) == 0),
                       pick_gap(burst));
         end
      end

      // Let the last colors come out, then hold a little longer for strays
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (dhc_pkg::LATENCY + 4) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("depth_to_hue_colormap_unit test passed");
      end else begin
         $display("depth_to_hue_colormap_unit test failed");
      end
      $finish;
   end

endmodule
